>>> hdl/aemc_pkg.sv
package aemc_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 8;

  typedef enum logic {
    MODE_SEARCH = 1'b0,
    MODE_INSERT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_EXACT = 2'd1,
    VERDICT_MAC   = 2'd2,
    VERDICT_IP    = 2'd3
  } verdict_t;

  // One stored ARP header; head packs hardware_type, protocol_type,
  // hardware_size, protocol_size and opcode, hardware_type on top.
  typedef struct packed {
    logic [63:0] head;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } entry_t;

  // Search beat walking down the chain of cells.
  typedef struct packed {
    logic     vld;
    logic     hit;
    verdict_t verdict;
  } token_t;

endpackage

>>> hdl/arp_entry_match_cache.sv
// Insert: the entry shifts in at accept; its result passes done_r, then the output register.
// Search: the key beat is registered in inj_r and walks the chain one cell per cycle, and its
//   verdict is captured at the tail. In both modes in_tready is low until the output takes it.
// One item is in flight at a time; a finished result waits in the output register.
// Reset (rst_n low, synchronous) clears every entry valid bit; entry data is not cleared.
module arp_entry_match_cache (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // hardware_type, protocol_type, hardware_size, protocol_size, opcode,
  // sender_mac, sender_ip, target_mac, target_ip
  input  logic [aemc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [aemc_pkg::OUT_DATA_W-1:0] out_tdata  // verdict, evicted, zero pad
);
  import aemc_pkg::*;

  entry_t   in_entry;
  logic     in_fire;
  logic     ins_fire;
  logic     srch_fire;
  logic     complete;

  logic     busy_r;
  logic     done_r;
  verdict_t verdict_r;
  logic     evict_r;
  entry_t   key_r;
  token_t   inj_r;
  token_t   inj_nxt;
  logic     out_tvalid_r;
  verdict_t out_verdict_r;
  logic     out_evicted_r;

  entry_t   ent_w [TABLE_DEPTH+1];
  logic     vld_w [TABLE_DEPTH+1];
  token_t   tok_w [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0] tok_vld;

  assign in_entry.head       = {in_tdata[15:0], in_tdata[31:16], in_tdata[39:32],
                                in_tdata[47:40], in_tdata[63:48]};
  assign in_entry.sender_mac = in_tdata[111:64];
  assign in_entry.sender_ip  = in_tdata[143:112];
  assign in_entry.target_mac = in_tdata[191:144];
  assign in_entry.target_ip  = in_tdata[223:192];

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign ins_fire  = in_fire && (in_tuser == MODE_INSERT);
  assign srch_fire = in_fire && (in_tuser == MODE_SEARCH);
  assign complete  = done_r && (!out_tvalid_r || out_tready);

  always_comb begin
    inj_nxt         = '0;
    inj_nxt.vld     = srch_fire;
    inj_nxt.verdict = VERDICT_NONE;
  end

  // chain of cells, cell 0 newest
  assign ent_w[0] = in_entry;
  assign vld_w[0] = 1'b1;
  assign tok_w[0] = inj_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    aemc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (ins_fire),
      .prev_entry (ent_w[g]),
      .prev_valid (vld_w[g]),
      .key        (key_r),
      .tok_in     (tok_w[g]),
      .entry_out  (ent_w[g+1]),
      .valid_out  (vld_w[g+1]),
      .tok_out    (tok_w[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_tok_vld
    assign tok_vld[g] = tok_w[g].vld;
  end

  always_ff @(posedge clk) begin
    if (srch_fire) begin
      key_r <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      done_r        <= 1'b0;
      verdict_r     <= VERDICT_NONE;
      evict_r       <= 1'b0;
      inj_r         <= '0;
      out_tvalid_r  <= 1'b0;
      out_verdict_r <= VERDICT_NONE;
      out_evicted_r <= 1'b0;
    end else begin
      inj_r <= inj_nxt;
      if (ins_fire) begin
        busy_r    <= 1'b1;
        done_r    <= 1'b1;
        verdict_r <= VERDICT_NONE;
        evict_r   <= vld_w[TABLE_DEPTH];
      end else if (srch_fire) begin
        busy_r <= 1'b1;
      end else if (tok_w[TABLE_DEPTH].vld) begin
        // capture search outcome as it leaves the tail
        done_r    <= 1'b1;
        verdict_r <= tok_w[TABLE_DEPTH].verdict;
        evict_r   <= 1'b0;
      end else if (complete) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
      end
      if (complete) begin
        out_tvalid_r  <= 1'b1;
        out_verdict_r <= verdict_r;
        out_evicted_r <= evict_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_evicted_r, out_verdict_r};

  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one search beat in the chain");

  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ($countones(tok_vld) == 0))
    else $error("search beat in the chain while idle");

  a_tok_exit: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[TABLE_DEPTH].vld |-> (busy_r && !done_r))
    else $error("search beat left the chain outside a search");

  a_ins_head: assert property (@(posedge clk) disable iff (!rst_n)
    ins_fire |=> vld_w[1])
    else $error("insert did not mark the head entry valid");

endmodule

>>> hdl/aemc_cell.sv
module aemc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  aemc_pkg::entry_t prev_entry,
  input  logic             prev_valid,
  input  aemc_pkg::entry_t key,
  input  aemc_pkg::token_t tok_in,
  output aemc_pkg::entry_t entry_out,
  output logic             valid_out,
  output aemc_pkg::token_t tok_out
);
  import aemc_pkg::*;

  entry_t entry_r;
  logic   valid_r;
  token_t tok_r;
  token_t tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    // first matching entry along the chain decides
    if (tok_in.vld && !tok_in.hit && valid_r) begin
      if (entry_r == key) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.verdict = VERDICT_EXACT;
      end else if (entry_r.sender_mac == key.sender_mac) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.verdict = VERDICT_MAC;
      end else if (entry_r.sender_ip == key.sender_ip) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.verdict = VERDICT_IP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (shift_en) begin
        valid_r <= prev_valid;
      end
      tok_r <= tok_nxt;
    end
  end

  assign entry_out = entry_r;
  assign valid_out = valid_r;
  assign tok_out   = tok_r;

endmodule
